// ===== design/gf2m_pkg.sv =====
// Shared types and constants for the GF(2^m) arithmetic unit.
// No dependencies; imported by gf2m_arithmetic_unit.
`timescale 1ns / 1ps

package gf2m_pkg;

    localparam int MAX_FIELD_BITS = 8;
    localparam int MIN_FIELD_BITS = 2;
    localparam int ELEM_W         = 8;                   // element / exponent width
    localparam int TBL_DEPTH      = 1 << MAX_FIELD_BITS; // log / antilog table depth
    localparam int LOG_W          = ELEM_W + 1;          // {valid, log}
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 9;
    localparam int IN_TDATA_W     = 24;
    localparam int OUT_TDATA_W    = 16;

    localparam logic [3:0] FIELD_BITS_RST = 4'd8;
    localparam logic [8:0] POLY_RST       = 9'd285;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_BITS     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIMITIVE_POLY = 1'd1;

    typedef enum logic [2:0] {
        FN_ADD  = 3'd0,
        FN_MUL  = 3'd1,
        FN_DIV  = 3'd2,
        FN_ALOG = 3'd3,
        FN_LOG  = 3'd4
    } t_func;

    typedef struct packed {
        logic              valid;
        logic [ELEM_W-1:0] lg;
    } t_log_entry;

endpackage

// ===== design/gf2m_arithmetic_unit.sv =====
// GF(2^m) arithmetic unit top level: table build sequencer and operation FSM.
// Depends on gf2m_pkg and gf2m_ram (log table, two copies, and antilog table).
`timescale 1ns / 1ps
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+----------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | func, operand_a, operand_b
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | result, error
//  cfg      | in        | i_cfg_wen (no wait)           | i_cfg_index, i_cfg_wdata
//
//  An item passes S_LOG and S_DONE (add, log, unused codes, and multiply / divide with a
//  zero operand or an error), S_LOG, S_EXP and S_DONE (multiply, divide otherwise) or
//  S_LOG, S_FOLD until no fold is left, S_EXP and S_DONE (antilog, up to 4 folds at m=2),
//  as the log and antilog RAMs have a registered read. One item is in flight at a time.
//  After reset and after every config write the tables are rebuilt: all 256 log-table
//  entries are cleared, then alpha^k is walked for k = 0 to 2^m-2; no beat is taken then.
//  A finished result waits in the output register while m_axis is stalled.

module gf2m_arithmetic_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // stream in
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [2:0] func, [10:3] operand_a, [18:11] operand_b, [23:19] zero
    input  logic [gf2m_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // stream out
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] result, [8] error, [15:9] zero
    output logic [gf2m_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // config write port
    input  logic                                i_cfg_wen,
    input  logic [gf2m_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gf2m_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    import gf2m_pkg::*;

    localparam int ADDR_W = $clog2(TBL_DEPTH);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_WALK_RD,
        S_WALK_WR,
        S_IDLE,
        S_LOG,
        S_FOLD,
        S_EXP,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [3:0]          r_field_bits, n_field_bits;
    logic [8:0]          r_poly, n_poly;
    logic [ADDR_W-1:0]   r_clr, n_clr;
    logic [ELEM_W-1:0]   r_k, n_k;
    logic [ELEM_W-1:0]   r_x, n_x;
    t_func               r_func, n_func;
    logic [ELEM_W-1:0]   r_a, n_a;
    logic [ELEM_W-1:0]   r_b, n_b;
    logic [ELEM_W-1:0]   r_fold, n_fold;
    logic [ELEM_W-1:0]   r_res, n_res;
    logic                r_err, n_err;
    logic                r_ovalid, n_ovalid;
    logic [ELEM_W-1:0]   r_out_res, n_out_res;
    logic                r_out_err, n_out_err;

    logic [3:0]          w_m;
    logic [ELEM_W-1:0]   w_mask;
    logic [ELEM_W-1:0]   w_in_a, w_in_b;
    logic                w_accept;

    logic                w_log_we;
    logic [ADDR_W-1:0]   w_log_waddr;
    t_log_entry          w_log_wdata;
    logic [ADDR_W-1:0]   w_log0_raddr;
    t_log_entry          w_log0_rdata, w_log1_rdata;
    logic                w_alog_we;
    logic [ADDR_W-1:0]   w_alog_raddr;
    logic [ELEM_W-1:0]   w_alog_rdata;

    logic [ELEM_W:0]     w_sum;
    logic [ELEM_W-1:0]   w_exp;
    logic [ELEM_W-1:0]   w_fold_hi;
    logic [ELEM_W-1:0]   w_fold_exp;

    // multiply by alpha and reduce with the low m bits of the polynomial
    function automatic logic [ELEM_W-1:0] times_alpha(
        input logic [ELEM_W-1:0] x,
        input logic [3:0]        m,
        input logic [ELEM_W-1:0] mask,
        input logic [8:0]        poly
    );
        logic                top;
        logic [ELEM_W-1:0]   y;
        top = x[3'(m - 4'd1)];
        y   = (x << 1) & mask;
        if (top) begin
            y = y ^ (poly[ELEM_W-1:0] & mask);
        end
        return y;
    endfunction

    always_comb begin
        if (r_field_bits < 4'(MIN_FIELD_BITS)) begin
            w_m = 4'(MIN_FIELD_BITS);
        end else if (r_field_bits > 4'(MAX_FIELD_BITS)) begin
            w_m = 4'(MAX_FIELD_BITS);
        end else begin
            w_m = r_field_bits;
        end
    end

    // mask doubles as n = 2^m - 1
    assign w_mask   = ELEM_W'((9'd1 << w_m) - 9'd1);
    assign w_in_a   = s_axis_tdata[10:3] & w_mask;
    assign w_in_b   = s_axis_tdata[18:11] & w_mask;
    assign w_accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_out_err, r_out_res};

    // table write side
    assign w_log_we     = (r_state == S_CLEAR) ||
                          ((r_state == S_WALK_WR) && !w_log0_rdata.valid);
    assign w_log_waddr  = (r_state == S_CLEAR) ? r_clr : r_x;
    assign w_log_wdata  = (r_state == S_CLEAR) ? t_log_entry'('0) :
                                                 t_log_entry'{valid: 1'b1, lg: r_k};
    assign w_alog_we    = (r_state == S_WALK_RD);
    assign w_log0_raddr = (r_state == S_IDLE) ? w_in_a : r_x;

    // exponent for multiply / divide: la + lb or la + (n - lb), reduced once mod n
    always_comb begin
        if (r_func == FN_DIV) begin
            w_sum = {1'b0, w_log0_rdata.lg} + {1'b0, w_mask - w_log1_rdata.lg};
        end else begin
            w_sum = {1'b0, w_log0_rdata.lg} + {1'b0, w_log1_rdata.lg};
        end
        if (w_sum >= {1'b0, w_mask}) begin
            w_exp = ELEM_W'(w_sum - {1'b0, w_mask});
        end else begin
            w_exp = w_sum[ELEM_W-1:0];
        end
    end

    assign w_fold_hi    = r_fold >> w_m;
    assign w_fold_exp   = (r_fold == w_mask) ? '0 : r_fold;
    assign w_alog_raddr = (r_state == S_FOLD) ? w_fold_exp : w_exp;

    gf2m_ram #(.WIDTH(LOG_W), .DEPTH(TBL_DEPTH)) u_log0 (
        .i_clk   (i_clk),
        .i_we    (w_log_we),
        .i_waddr (w_log_waddr),
        .i_wdata (w_log_wdata),
        .i_raddr (w_log0_raddr),
        .o_rdata (w_log0_rdata)
    );

    gf2m_ram #(.WIDTH(LOG_W), .DEPTH(TBL_DEPTH)) u_log1 (
        .i_clk   (i_clk),
        .i_we    (w_log_we),
        .i_waddr (w_log_waddr),
        .i_wdata (w_log_wdata),
        .i_raddr (w_in_b),
        .o_rdata (w_log1_rdata)
    );

    gf2m_ram #(.WIDTH(ELEM_W), .DEPTH(TBL_DEPTH)) u_alog (
        .i_clk   (i_clk),
        .i_we    (w_alog_we),
        .i_waddr (r_k),
        .i_wdata (r_x),
        .i_raddr (w_alog_raddr),
        .o_rdata (w_alog_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_field_bits = r_field_bits;
        n_poly       = r_poly;
        n_clr        = r_clr;
        n_k          = r_k;
        n_x          = r_x;
        n_func       = r_func;
        n_a          = r_a;
        n_b          = r_b;
        n_fold       = r_fold;
        n_res        = r_res;
        n_err        = r_err;
        n_ovalid     = r_ovalid;
        n_out_res    = r_out_res;
        n_out_err    = r_out_err;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == ADDR_W'(TBL_DEPTH - 1)) begin
                    n_state = S_WALK_RD;
                    n_k     = '0;
                    n_x     = ELEM_W'(1);
                end
            end
            S_WALK_RD: begin
                n_state = S_WALK_WR;
            end
            S_WALK_WR: begin
                // log entry keeps the first k that reaches x
                n_k = r_k + 1'b1;
                n_x = times_alpha(r_x, w_m, w_mask, r_poly);
                if (r_k == w_mask - 1'b1) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_WALK_RD;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_func  = t_func'(s_axis_tdata[2:0]);
                    n_a     = w_in_a;
                    n_b     = w_in_b;
                    n_fold  = s_axis_tdata[18:11];
                    n_state = S_LOG;
                end
            end
            S_LOG: begin
                n_res   = '0;
                n_err   = 1'b0;
                n_state = S_DONE;
                case (r_func)
                    FN_ADD: begin
                        n_res = r_a ^ r_b;
                    end
                    FN_MUL: begin
                        if (r_a != '0 && r_b != '0) begin
                            if (w_log0_rdata.valid && w_log1_rdata.valid) begin
                                n_state = S_EXP;
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                    end
                    FN_DIV: begin
                        if (r_b == '0) begin
                            n_err = 1'b1;
                        end else if (r_a != '0) begin
                            if (w_log0_rdata.valid && w_log1_rdata.valid) begin
                                n_state = S_EXP;
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                    end
                    FN_ALOG: begin
                        n_state = S_FOLD;
                    end
                    FN_LOG: begin
                        if (r_a == '0 || !w_log0_rdata.valid) begin
                            n_err = 1'b1;
                        end else begin
                            n_res = w_log0_rdata.lg;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_FOLD: begin
                // fold high digits onto low ones: 2^m == 1 mod 2^m-1
                if (w_fold_hi == '0) begin
                    n_state = S_EXP;
                end else begin
                    n_fold = ELEM_W'({1'b0, w_fold_hi} + {1'b0, r_fold & w_mask});
                end
            end
            S_EXP: begin
                n_res   = w_alog_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid  = 1'b1;
                    n_out_res = r_res;
                    n_out_err = r_err;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase

        if (i_cfg_wen) begin
            case (i_cfg_index)
                CFG_FIELD_BITS:     n_field_bits = i_cfg_wdata[3:0];
                CFG_PRIMITIVE_POLY: n_poly       = i_cfg_wdata;
                default: begin
                end
            endcase
            n_state = S_CLEAR;
            n_clr   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_field_bits <= FIELD_BITS_RST;
            r_poly       <= POLY_RST;
            r_clr        <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_field_bits <= n_field_bits;
            r_poly       <= n_poly;
            r_clr        <= n_clr;
            r_ovalid     <= n_ovalid;
        end
        r_k       <= n_k;
        r_x       <= n_x;
        r_func    <= n_func;
        r_a       <= n_a;
        r_b       <= n_b;
        r_fold    <= n_fold;
        r_res     <= n_res;
        r_err     <= n_err;
        r_out_res <= n_out_res;
        r_out_err <= n_out_err;
    end

endmodule

// ===== design/gf2m_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module gf2m_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/gf2m_arithmetic_unit_tb.sv =====
// Self-checking testbench for gf2m_arithmetic_unit: directed table plus random
// phases over many field settings, each checked against an in-bench GF(2^m) predictor.
// Depends on gf2m_pkg and the gf2m_arithmetic_unit RTL.
`timescale 1ns / 1ps

module gf2m_arithmetic_unit_tb;

    import gf2m_pkg::*;

    // unused operation codes; the block answers them with zero
    localparam logic [2:0] FN_RSVD5 = 3'd5;
    localparam logic [2:0] FN_RSVD6 = 3'd6;
    localparam logic [2:0] FN_RSVD7 = 3'd7;

    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES      = 12;
    localparam int RAND_PER_PHASE   = 98;
    localparam int NUM_PHASES       = 13;
    localparam int NUM_ROWS         = 26;
    localparam int MAX_PRINTS       = 40;

    typedef struct packed {
        logic [7:0] result;
        logic       error;
    } t_gf_out;

    typedef struct packed {
        logic [2:0] fn;
        logic [7:0] a;
        logic [7:0] b;
        logic       typed;  // expected value given in the row
        logic [7:0] res;
        logic       err;
    } t_row;

    // rows run at the reset setting: m = 8, x^8+x^4+x^3+x^2+1
    localparam t_row DIR_ROWS [NUM_ROWS] = '{
        '{FN_ADD,   8'hFF, 8'h00, 1'b1, 8'hFF, 1'b0},
        '{FN_ADD,   8'hAA, 8'h55, 1'b1, 8'hFF, 1'b0},
        '{FN_ADD,   8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        '{FN_MUL,   8'h00, 8'h37, 1'b1, 8'h00, 1'b0},
        '{FN_MUL,   8'h37, 8'h00, 1'b1, 8'h00, 1'b0},
        '{FN_MUL,   8'h01, 8'hFF, 1'b1, 8'hFF, 1'b0},
        '{FN_MUL,   8'h80, 8'h02, 1'b1, 8'h1D, 1'b0},
        '{FN_MUL,   8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{FN_DIV,   8'h12, 8'h00, 1'b1, 8'h00, 1'b1},
        '{FN_DIV,   8'h00, 8'h00, 1'b1, 8'h00, 1'b1},
        '{FN_DIV,   8'h00, 8'h05, 1'b1, 8'h00, 1'b0},
        '{FN_DIV,   8'h5A, 8'h5A, 1'b1, 8'h01, 1'b0},
        '{FN_DIV,   8'h01, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{FN_ALOG,  8'h00, 8'h00, 1'b1, 8'h01, 1'b0},
        '{FN_ALOG,  8'h00, 8'h01, 1'b1, 8'h02, 1'b0},
        '{FN_ALOG,  8'hFF, 8'hFF, 1'b1, 8'h01, 1'b0},
        '{FN_ALOG,  8'h00, 8'h08, 1'b1, 8'h1D, 1'b0},
        '{FN_ALOG,  8'h00, 8'hFE, 1'b0, 8'h00, 1'b0},
        '{FN_LOG,   8'h00, 8'hFF, 1'b1, 8'h00, 1'b1},
        '{FN_LOG,   8'h01, 8'h00, 1'b1, 8'h00, 1'b0},
        '{FN_LOG,   8'h02, 8'h00, 1'b1, 8'h01, 1'b0},
        '{FN_LOG,   8'h1D, 8'h00, 1'b1, 8'h08, 1'b0},
        '{FN_LOG,   8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{FN_RSVD5, 8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0},
        '{FN_RSVD6, 8'hAA, 8'h55, 1'b1, 8'h00, 1'b0},
        '{FN_RSVD7, 8'h55, 8'hAA, 1'b1, 8'h00, 1'b0}
    };

    // field settings per random phase; degree 0/1/9/15 saturate, 0x1FF and 0x1F
    // are not primitive, 0x1F7 has junk above the x^m bit
    localparam logic [3:0] PHASE_FB [NUM_PHASES] = '{
        4'd2, 4'd3, 4'd4, 4'd5, 4'd8, 4'd0, 4'd6, 4'd15, 4'd4, 4'd1, 4'd7, 4'd9, 4'd8
    };
    localparam logic [8:0] PHASE_POLY [NUM_PHASES] = '{
        9'h007, 9'h00B, 9'h013, 9'h025, 9'h1FF, 9'h1F7, 9'h043,
        9'h02B, 9'h01F, 9'h000, 9'h089, 9'h11D, 9'h11D
    };

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_wen     = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata   = '0;

    // bench copy of the configuration registers
    logic [3:0] cfg_field_bits = FIELD_BITS_RST;
    logic [8:0] cfg_poly       = POLY_RST;

    t_gf_out     pending_results [$];
    int unsigned beats_in    = 0;
    int unsigned beats_out   = 0;
    int unsigned mismatches  = 0;
    int unsigned burst_left  = 0;
    int unsigned long_holds  = 0;
    bit          hold_request = 1'b0;

    gf2m_arithmetic_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever begin
            #1 i_clk = ~i_clk;
        end
    end

    // ---------------- GF(2^m) predictor ----------------

    function automatic int unsigned field_degree();
        int unsigned m;
        m = cfg_field_bits;
        if (m < MIN_FIELD_BITS) m = MIN_FIELD_BITS;
        if (m > MAX_FIELD_BITS) m = MAX_FIELD_BITS;
        return m;
    endfunction

    // x * alpha, reduced; only the low m polynomial bits count
    function automatic logic [7:0] shift_alpha(logic [7:0] x, int unsigned m);
        logic [7:0] mask;
        logic       top;
        mask = 8'((1 << m) - 1);
        top  = x[m-1];
        x    = (x << 1) & mask;
        if (top) x = x ^ (cfg_poly[7:0] & mask);
        return x;
    endfunction

    function automatic logic [7:0] alpha_power(int unsigned k, int unsigned m);
        logic [7:0] x;
        x = 8'd1;
        k = k % ((1 << m) - 1);
        for (int unsigned i = 0; i < k; i++) x = shift_alpha(x, m);
        return x;
    endfunction

    // false when v is not reached by powers of alpha (non-primitive polynomial)
    function automatic bit find_log(logic [7:0] v, int unsigned m, output int unsigned lg);
        logic [7:0] x;
        x  = 8'd1;
        lg = 0;
        for (int unsigned k = 0; k < (1 << m) - 1; k++) begin
            if (x == v) begin
                lg = k;
                return 1'b1;
            end
            x = shift_alpha(x, m);
        end
        return 1'b0;
    endfunction

    function automatic t_gf_out gf_expected(logic [2:0] fn, logic [7:0] a_raw,
                                            logic [7:0] b_raw);
        int unsigned m, n, la, lb;
        logic [7:0]  a, b;
        t_gf_out     r;
        m = field_degree();
        n = (1 << m) - 1;
        a = a_raw & 8'(n);
        b = b_raw & 8'(n);
        r = '0;
        case (fn)
            FN_ADD: r.result = a ^ b;
            FN_MUL: begin
                if (a != 0 && b != 0) begin
                    if (find_log(a, m, la) && find_log(b, m, lb))
                        r.result = alpha_power((la + lb) % n, m);
                    else
                        r.error = 1'b1;
                end
            end
            FN_DIV: begin
                if (b == 0) begin
                    r.error = 1'b1;
                end else if (a != 0) begin
                    if (find_log(a, m, la) && find_log(b, m, lb))
                        r.result = alpha_power((la + n - lb) % n, m);
                    else
                        r.error = 1'b1;
                end
            end
            FN_ALOG: r.result = alpha_power(b_raw, m);
            FN_LOG: begin
                if (a == 0 || !find_log(a, m, la)) r.error = 1'b1;
                else r.result = 8'(la);
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // ---------------- drivers ----------------

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_op(logic [2:0] fn, logic [7:0] a, logic [7:0] b, t_gf_out want);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tdata  <= {5'd0, b, a, fn};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results = {pending_results, want};
        beats_in++;
        @(negedge i_clk);
    endtask

    // drop valid and wait until every expected result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [8:0] val);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        if (idx == CFG_FIELD_BITS) cfg_field_bits = val[3:0];
        else cfg_poly = val;
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_operand(int unsigned m);
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'hFF;
            3, 4, 5: return 8'($urandom_range(0, (1 << m) - 1));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ---------------- receiver ----------------

    initial begin
        logic [15:0] rx_cycle;
        int unsigned held;
        rx_cycle = '0;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                held = 0;
                while (held < LONG_HOLD_CYCLES) begin
                    @(negedge i_clk);
                    held++;
                end
                hold_request = 1'b0;
                long_holds++;
            end else begin
                case (rx_cycle[8:6])
                    3'd0, 3'd1, 3'd6: m_axis_tready <= 1'b1;
                    3'd2: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    3'd3: m_axis_tready <= ($urandom_range(0, 2) == 0);
                    3'd4: m_axis_tready <= (rx_cycle[1:0] != 2'b11);
                    3'd5: m_axis_tready <= rx_cycle[2];
                    default: m_axis_tready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // ---------------- checking ----------------

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (mismatches < MAX_PRINTS)
            $display("[%0t] mismatch on result beat %0d: %s got 0x%0h want 0x%0h",
                     $realtime, beats_out, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_gf_out got;
        t_gf_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.result = m_axis_tdata[7:0];
            got.error  = m_axis_tdata[8];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", 32'(m_axis_tdata), 0);
            end else begin
                want = pending_results.pop_front();
                if (got.result !== want.result)
                    report_mismatch("result", 32'(got.result), 32'(want.result));
                if (got.error !== want.error)
                    report_mismatch("error", 32'(got.error), 32'(want.error));
            end
            beats_out++;
        end
    end

    // stall watchdog: no beat and no register write for too long
    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                i_cfg_wen)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no progress for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    // ---------------- main sequence ----------------

    initial begin
        t_row        row;
        t_gf_out     want;
        logic [2:0]  fn;
        logic [7:0]  a, b;
        int unsigned sel, m;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            row = DIR_ROWS[i];
            if (row.typed) begin
                want.result = row.res;
                want.error  = row.err;
            end else begin
                want = gf_expected(row.fn, row.a, row.b);
            end
            send_op(row.fn, row.a, row.b, want);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            if (p[0]) begin
                write_reg(CFG_PRIMITIVE_POLY, PHASE_POLY[p]);
                write_reg(CFG_FIELD_BITS, {5'd0, PHASE_FB[p]});
            end else begin
                write_reg(CFG_FIELD_BITS, {5'd0, PHASE_FB[p]});
                write_reg(CFG_PRIMITIVE_POLY, PHASE_POLY[p]);
            end
            m = field_degree();
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                // back-pressure test: output held off while input keeps offering
                if ((p == 4 || p == 10) && k == 20) hold_request = 1'b1;
                sel = $urandom_range(0, 19);
                fn  = (sel < 17) ? 3'(sel % 5) : 3'(sel - 12);
                a   = pick_operand(m);
                b   = (fn == FN_ALOG) ? 8'($urandom_range(0, 255)) : pick_operand(m);
                send_op(fn, a, b, gf_expected(fn, a, b));
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d operations in, %0d results out, over %0d field settings",
                 beats_in, beats_out, NUM_PHASES + 1);
        $display("Included saturated degrees, non-primitive polynomials and %0d long output stalls",
                 long_holds);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     pending_results.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
